### hw/rtl/lcf_pkg.sv
// lstm cell forward package: codes, fixed-point helpers and activation tables
`default_nettype none
package lcf_pkg;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_UNIT_COUNT  = 2'd0,
    CFG_INPUT_COUNT = 2'd1,
    CFG_EMIT_EVERY  = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_t;

  localparam int unsigned TAB_SIZE = 1024;
  localparam longint unsigned ONE62 = 64'd1 << 62;

  typedef logic signed [15:0] tab_t [TAB_SIZE];
  typedef longint unsigned base_t [11];

  // restoring divide, used only while the tables are built
  function automatic longint unsigned udiv(input longint unsigned n, input longint unsigned d);
    longint unsigned rem;
    longint unsigned quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned mul62(input longint unsigned a, input longint unsigned b);
    longint unsigned ah, al, bh, bl, lo, m1, m2, hi, t, high, low;
    ah = a >> 32;
    al = a & 64'hFFFF_FFFF;
    bh = b >> 32;
    bl = b & 64'hFFFF_FFFF;
    lo = al * bl;
    m1 = ah * bl;
    m2 = al * bh;
    hi = ah * bh;
    t = (lo >> 32) + (m1 & 64'hFFFF_FFFF) + (m2 & 64'hFFFF_FFFF);
    high = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
    low = (t << 32) | (lo & 64'hFFFF_FFFF);
    return (high << 2) | (low >> 62);
  endfunction

  function automatic longint unsigned exp_neg(input int unsigned n, input base_t eb);
    longint unsigned r;
    r = ONE62;
    for (int j = 0; j < 11; j++) begin
      if (((n >> j) & 1) != 0) r = mul62(r, eb[j]);
    end
    return r;
  endfunction

  function automatic tab_t build_tab(input bit is_tanh);
    base_t eb;
    tab_t tb;
    longint unsigned term, sum, e, d, num, f, d2, t, sg;
    int unsigned k, am;
    bit neg;
    term = ONE62;
    sum = ONE62;
    k = 1;
    while (term != 0) begin
      term = udiv(term, 64'(64 * k));
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
      k++;
    end
    eb[0] = sum;
    for (int j = 1; j < 11; j++) eb[j] = mul62(eb[j-1], eb[j-1]);
    for (int unsigned i = 0; i < TAB_SIZE; i++) begin
      neg = (i < 512);
      am = neg ? (512 - i) : (i - 512);
      e = exp_neg(am, eb);
      d = (ONE62 + e) >> 12;
      num = neg ? e : ONE62;
      f = exp_neg(2 * am, eb);
      d2 = (ONE62 + f) >> 12;
      t = udiv(ONE62 - f + (d2 >> 1), d2);
      sg = udiv(num + (d >> 1), d);
      if (is_tanh) tb[i] = neg ? -16'(t) : 16'(t);
      else tb[i] = 16'(sg);
    end
    return tb;
  endfunction

  localparam tab_t SIG_TAB  = build_tab(1'b0);
  localparam tab_t TANH_TAB = build_tab(1'b1);

  // q10.24 to q4.12, round half up, saturate
  function automatic logic signed [15:0] q12_sat(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [22:0] sh;
    t = 35'(v) + 35'sd2048;
    sh = 23'(t >>> 12);
    if (sh > 23'sd32767) return 16'sh7FFF;
    if (sh < -23'sd32768) return 16'sh8000;
    return 16'(sh);
  endfunction

  function automatic logic [9:0] tab_idx(input logic [15:0] a);
    return {~a[15], a[14:6]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lcf_if.sv
// lstm cell forward channel interfaces
`default_nettype none
interface lcf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [10:0]        address;
  logic signed [15:0] value;
  logic               step_end;
  logic               series_end;
  modport source(output valid, operation, address, value, step_end, series_end, input ready);
  modport sink(input valid, operation, address, value, step_end, series_end, output ready);
endinterface

interface lcf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         unit_index;
  logic signed [15:0] hidden_value;
  logic               series_final;
  logic               last;
  modport source(output valid, unit_index, hidden_value, series_final, last, input ready);
  modport sink(input valid, unit_index, hidden_value, series_final, last, output ready);
endinterface

interface lcf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/lstm_cell_forward_top.sv
// lstm cell forward top level
// usage:
//   in_chan carries weight loads, bias loads and feature elements. weights
//   and biases are written one word per item.
//   a feature element flagged step_end starts a step: the gate pass reads one
//   64-bit weight row (four gates) per cycle from the weight memory, then
//   drains; each unit is then updated in the read, multiply, cell, hidden and
//   output states through the cell and hidden memories. in_chan is not ready
//   during a step and ready again once the last unit is written.
//   out_chan gives one item per unit, in unit order, either every step or at
//   series end only (cfg register 2). last marks the final unit.
//   a stalled out_chan holds the unit update that wants to emit next.
//   cfg_chan is always ready; write it only while the block is idle.
//   reset sets the counts to 16, emit at series end, and hidden and cell
//   state to zero. weights, biases and features hold garbage until loaded.
`default_nettype none
module lstm_cell_forward_top
  import lcf_pkg::*;
#(
  parameter int UNITS    = 16,
  parameter int FEATURES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lcf_in_if.sink        in_chan,
  lcf_out_if.source     out_chan,
  lcf_cfg_if.sink       cfg_chan
);

  localparam int WROWS  = UNITS * (UNITS + FEATURES);
  localparam int WDEPTH = 4 * WROWS;
  localparam int BDEPTH = 4 * UNITS;
  localparam int RW     = $clog2(WROWS);
  localparam int UW     = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int FW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int NUW    = $clog2(UNITS + 1);
  localparam int NIW    = $clog2(FEATURES + 1);
  localparam int SW     = $clog2(UNITS + FEATURES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_A_RUN, S_A_DRAIN, S_B_RD, S_B_MUL, S_B_CELL, S_B_HID, S_B_OUT
  } state_t;

  state_t state_r;

  logic [4:0] unit_count_r;
  logic [4:0] input_count_r;
  logic       emit_every_r;
  logic       series_r;

  logic [3:0][15:0] weight_mem [WROWS];
  logic [3:0][15:0] bias_mem   [UNITS];
  logic [15:0]      feat_mem   [FEATURES];
  logic [15:0]      hid_mem    [UNITS];
  logic [15:0]      cell_mem   [UNITS];
  logic [63:0]      gate_mem   [UNITS];
  logic [UNITS-1:0] hc_valid_r;

  logic [RW-1:0] row_r;
  logic [SW-1:0] s_r;
  logic [UW-1:0] o_r;
  logic [UW-1:0] bo_r;

  logic [3:0][15:0] w_rd_r;
  logic [3:0][15:0] b_rd_r;
  logic [15:0]      h_rd_r;
  logic             hv_rd_r;
  logic [15:0]      f_rd_r;
  logic [63:0]      g_rd_r;
  logic [15:0]      c_rd_r;
  logic             cv_rd_r;

  logic          p1_v_r, p1_first_r, p1_last_r, p1_hid_r;
  logic [UW-1:0] p1_o_r;
  logic          p2_v_r, p2_first_r, p2_last_r;
  logic [UW-1:0] p2_o_r;
  logic [3:0][15:0]   b2_r;
  logic signed [31:0] prod_r [4];
  logic [31:0]        acc_r  [4];
  logic          g_v_r;
  logic [UW-1:0] g_o_r;
  logic          t_v_r;
  logic [UW-1:0] t_o_r;
  logic [3:0][15:0] tab_r;

  logic signed [31:0] pfc_r, pig_r, ph_r;
  logic signed [15:0] th_r;

  logic        out_valid_r;
  logic [3:0]  out_unit_r;
  logic [15:0] out_hidden_r;
  logic        out_final_r;
  logic        out_last_r;

  logic [NUW-1:0] nu;
  logic [NIW-1:0] ni;
  logic [SW-1:0]  stride;
  logic           in_acc, cfg_acc, step_start, a_last, emit, b_go, b_wr;
  logic [31:0]    addr_ext;
  logic signed [15:0] x_sel, c_old, c_nxt, h_nxt;
  logic [FW-1:0]  f_idx;

  always_comb begin
    if (unit_count_r == 5'd0) nu = NUW'(1);
    else if (32'(unit_count_r) > UNITS) nu = NUW'(UNITS);
    else nu = NUW'(unit_count_r);
    if (input_count_r == 5'd0) ni = NIW'(1);
    else if (32'(input_count_r) > FEATURES) ni = NIW'(FEATURES);
    else ni = NIW'(input_count_r);
    stride = SW'(nu) + SW'(ni);
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign addr_ext = 32'(in_chan.address);
  assign step_start = in_acc && (in_chan.operation == OP_FEATURE) && in_chan.step_end;
  assign a_last = (32'(o_r) == 32'(nu) - 1) && (s_r == stride - SW'(1));
  assign f_idx  = FW'(s_r - SW'(nu));
  assign x_sel  = p1_hid_r ? (hv_rd_r ? h_rd_r : 16'sd0) : f_rd_r;
  assign c_old  = cv_rd_r ? c_rd_r : 16'sd0;
  assign c_nxt  = q12_sat(34'(pfc_r) + 34'(pig_r));
  assign h_nxt  = q12_sat(34'(ph_r));
  assign emit   = emit_every_r || series_r;
  assign b_go   = !emit || !out_valid_r || out_chan.ready;
  assign b_wr   = (state_r == S_B_OUT) && b_go;

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.operation == OP_WEIGHT && addr_ext < WDEPTH)
      weight_mem[addr_ext[RW+1:2]][in_chan.address[1:0]] <= in_chan.value;
    if (in_acc && in_chan.operation == OP_BIAS && addr_ext < BDEPTH)
      bias_mem[addr_ext[UW+1:2]][in_chan.address[1:0]] <= in_chan.value;
    if (in_acc && in_chan.operation == OP_FEATURE && addr_ext < FEATURES)
      feat_mem[addr_ext[FW-1:0]] <= in_chan.value;
    if (t_v_r) gate_mem[t_o_r] <= tab_r;
    if (b_wr) begin
      hid_mem[bo_r]  <= series_r ? 16'd0 : h_nxt;
      cell_mem[bo_r] <= series_r ? 16'd0 : c_nxt;
    end
    w_rd_r <= weight_mem[row_r];
    b_rd_r <= bias_mem[o_r];
    h_rd_r <= hid_mem[UW'(s_r)];
    f_rd_r <= feat_mem[f_idx];
    g_rd_r <= gate_mem[bo_r];
    c_rd_r <= cell_mem[bo_r];
  end

  // gate datapath
  always_ff @(posedge clk) begin
    hv_rd_r <= hc_valid_r[UW'(s_r)];
    cv_rd_r <= hc_valid_r[bo_r];
    p1_first_r <= (s_r == SW'(0));
    p1_last_r  <= (s_r == stride - SW'(1));
    p1_hid_r   <= (s_r < SW'(nu));
    p1_o_r     <= o_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_o_r     <= p1_o_r;
    b2_r       <= b_rd_r;
    g_o_r      <= p2_o_r;
    t_o_r      <= g_o_r;
    for (int q = 0; q < 4; q++) begin
      prod_r[q] <= x_sel * $signed(w_rd_r[q]);
      if (p2_v_r)
        acc_r[q] <= (p2_first_r ? {{4{b2_r[q][15]}}, b2_r[q], 12'd0} : acc_r[q])
                    + prod_r[q];
      tab_r[q] <= (q == 2) ? TANH_TAB[tab_idx(q12_sat(34'($signed(acc_r[q]))))]
                           : SIG_TAB[tab_idx(q12_sat(34'($signed(acc_r[q]))))];
    end
    pfc_r  <= $signed(g_rd_r[15:0]) * c_old;
    pig_r  <= $signed(g_rd_r[31:16]) * $signed(g_rd_r[47:32]);
    th_r   <= TANH_TAB[tab_idx(c_nxt)];
    ph_r   <= $signed(g_rd_r[63:48]) * th_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      unit_count_r  <= 5'd16;
      input_count_r <= 5'd16;
      emit_every_r  <= 1'b0;
      series_r      <= 1'b0;
      hc_valid_r    <= '0;
      row_r         <= '0;
      s_r           <= '0;
      o_r           <= '0;
      bo_r          <= '0;
      p1_v_r        <= 1'b0;
      p2_v_r        <= 1'b0;
      g_v_r         <= 1'b0;
      t_v_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_unit_r    <= '0;
      out_hidden_r  <= '0;
      out_final_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_chan.index)
          CFG_UNIT_COUNT:  unit_count_r  <= cfg_chan.data;
          CFG_INPUT_COUNT: input_count_r <= cfg_chan.data;
          CFG_EMIT_EVERY:  emit_every_r  <= cfg_chan.data[0];
          default: ;
        endcase
      end
      p1_v_r <= (state_r == S_A_RUN);
      p2_v_r <= p1_v_r;
      g_v_r  <= p2_v_r && p2_last_r;
      t_v_r  <= g_v_r;
      if (out_chan.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (step_start) begin
            state_r  <= S_A_RUN;
            series_r <= in_chan.series_end;
            row_r    <= '0;
            s_r      <= '0;
            o_r      <= '0;
          end
        end
        S_A_RUN: begin
          row_r <= row_r + RW'(1);
          if (s_r == stride - SW'(1)) begin
            s_r <= '0;
            o_r <= o_r + UW'(1);
          end else begin
            s_r <= s_r + SW'(1);
          end
          if (a_last) state_r <= S_A_DRAIN;
        end
        S_A_DRAIN: begin
          if (!p1_v_r && !p2_v_r && !g_v_r && !t_v_r) begin
            bo_r    <= '0;
            state_r <= S_B_RD;
          end
        end
        S_B_RD:   state_r <= S_B_MUL;
        S_B_MUL:  state_r <= S_B_CELL;
        S_B_CELL: state_r <= S_B_HID;
        S_B_HID:  state_r <= S_B_OUT;
        S_B_OUT: begin
          if (b_go) begin
            hc_valid_r[bo_r] <= 1'b1;
            if (emit) begin
              out_valid_r  <= 1'b1;
              out_unit_r   <= 4'(bo_r);
              out_hidden_r <= h_nxt;
              out_final_r  <= series_r;
              out_last_r   <= (32'(bo_r) == 32'(nu) - 1);
            end
            if (32'(bo_r) == 32'(nu) - 1) begin
              state_r <= S_IDLE;
            end else begin
              bo_r    <= bo_r + UW'(1);
              state_r <= S_B_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.unit_index   = out_unit_r;
  assign out_chan.hidden_value = out_hidden_r;
  assign out_chan.series_final = out_final_r;
  assign out_chan.last         = out_last_r;

endmodule
`default_nettype wire

### hw/rtl/lcf_checker.sv
// lstm cell forward port checker and its bind
`default_nettype none
module lcf_checker
  import lcf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic        in_step_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_hidden_value,
  input wire logic [3:0]  out_unit_index
);

  logic in_acc;
  logic step_acc;
  assign in_acc   = in_valid && in_ready;
  assign step_acc = in_acc && (in_operation == OP_FEATURE) && in_step_end;

  // loads and plain features never stall the next item
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !step_acc |=> in_ready) else $error("not ready after load item");

  // a step end starts the computation
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_acc |=> !in_ready) else $error("ready right after step end");

  // ready only drops on a step end
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(step_acc)) else $error("ready fell without step end");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hidden_value)
      && $stable(out_unit_index)) else $error("stalled result changed");

endmodule

bind lstm_cell_forward_top lcf_checker u_lcf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_operation     (in_chan.operation),
  .in_step_end      (in_chan.step_end),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_hidden_value (out_chan.hidden_value),
  .out_unit_index   (out_chan.unit_index)
);
`default_nettype wire
